>>> rtl/two_key_long_short_press_classifier_defines.svh
// assertion macros for the press classifier
`ifndef TWO_KEY_LONG_SHORT_PRESS_CLASSIFIER_DEFINES_SVH
`define TWO_KEY_LONG_SHORT_PRESS_CLASSIFIER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define TKLSP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tklsp assertion failed");

// next-cycle implication, checked out of reset
`define TKLSP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tklsp assertion failed");

`endif

>>> rtl/tklsp_pkg.sv
package tklsp_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int CFG_W       = 16;
    localparam int START_W     = 8;
    localparam int CMP_W       = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

    localparam logic [CFG_W-1:0]   SHORT_RESET     = CFG_W'(20);
    localparam logic [CFG_W-1:0]   LONG_RESET      = CFG_W'(150);
    localparam logic [CFG_W-1:0]   SHORT_END_RESET = CFG_W'(100);
    localparam logic [START_W-1:0] STARTUP_RESET   = START_W'(10);

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_SCAN  = 2'd1,
        ACT_CLEAR = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        REG_SHORT     = 2'd0,
        REG_LONG      = 2'd1,
        REG_SHORT_END = 2'd2,
        REG_STARTUP   = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } event_t;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] count;
        event_t                 event_code;
        logic                   latched;
    } key_state_t;

    function automatic logic [COUNT_WIDTH-1:0] count_from_cfg(input logic [CFG_W-1:0] v);
        logic [CMP_W-1:0] w;
        w = CMP_W'(v);
        return w[COUNT_WIDTH-1:0];
    endfunction

endpackage

>>> rtl/tklsp_classify.sv
module tklsp_classify
    import tklsp_pkg::*;
(
    input  key_state_t       key_cur,
    input  logic             pressed,
    input  logic [CFG_W-1:0] long_ticks,
    input  logic [CFG_W-1:0] short_end_ticks,
    input  logic [CFG_W-1:0] release_thr,
    output key_state_t       key_new
);

    logic [CMP_W-1:0] count_ext;

    assign count_ext = CMP_W'(key_cur.count);

    always_comb begin
        key_new = key_cur;
        if (pressed) begin
            if (count_ext >= CMP_W'(long_ticks)) begin
                key_new.count = count_from_cfg(long_ticks);
                if (!key_cur.latched) begin
                    key_new.latched    = 1'b1;
                    key_new.event_code = EV_LONG;
                end
            end
        end else begin
            if (count_ext <= CMP_W'(release_thr)) begin
                key_new.event_code = EV_NONE;
            end else if (count_ext < CMP_W'(short_end_ticks)) begin
                key_new.event_code = EV_SHORT;
            end
            key_new.latched = 1'b0;
            key_new.count   = '0;
        end
    end

endmodule

>>> rtl/two_key_long_short_press_classifier.sv
// channel  | handshake          | payload
// s_       | s_valid / s_ready  | s_action, s_key0_down, s_key1_down, s_clear_mask
// m_       | m_valid / m_ready  | m_key0_event, m_key1_event, m_key0_held, m_key1_held
// cfg_     | cfg_wen            | cfg_index, cfg_wdata
//
// one transaction per cycle while s_ready is high; its result is registered and shown the next cycle
// the state update is a single compare and increment stage per key
// s_ready is high whenever the result register is empty or being taken
// a stalled result holds while no new transaction enters
// aresetn is synchronous, clears state and restores register defaults
`include "two_key_long_short_press_classifier_defines.svh"

module two_key_long_short_press_classifier
    import tklsp_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,

    input  logic             cfg_wen,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata,

    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_action,
    input  logic             s_key0_down,
    input  logic             s_key1_down,
    input  logic [1:0]       s_clear_mask,

    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_key0_event,
    output logic [1:0]       m_key1_event,
    output logic             m_key0_held,
    output logic             m_key1_held
);

    logic [CFG_W-1:0]   short_reg, short_next;
    logic [CFG_W-1:0]   long_reg, long_next;
    logic [CFG_W-1:0]   short_end_reg, short_end_next;
    logic [START_W-1:0] startup_reg, startup_next;
    logic [CFG_W-1:0]   thr_reg, thr_next;

    key_state_t [1:0] key_reg, key_next, key_scan;
    logic [1:0]       level_reg, level_next, level_in;

    logic       m_valid_reg, m_valid_next;
    logic [1:0] ev0_reg, ev0_next, ev1_reg, ev1_next;
    logic       held0_reg, held0_next, held1_reg, held1_next;

    logic s_accept;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;
    assign level_in = {s_key1_down, s_key0_down};

    for (genvar g = 0; g < 2; g++) begin : g_key
        tklsp_classify u_classify (
            .key_cur         (key_reg[g]),
            .pressed         (level_in[g]),
            .long_ticks      (long_reg),
            .short_end_ticks (short_end_reg),
            .release_thr     (thr_reg),
            .key_new         (key_scan[g])
        );
    end

    always_comb begin
        short_next     = short_reg;
        long_next      = long_reg;
        short_end_next = short_end_reg;
        startup_next   = startup_reg;
        thr_next       = thr_reg;
        key_next       = key_reg;
        level_next     = level_reg;

        if (cfg_wen) begin
            case (reg_index_t'(cfg_index))
                REG_SHORT:     short_next     = cfg_wdata;
                REG_LONG:      long_next      = cfg_wdata;
                REG_SHORT_END: short_end_next = cfg_wdata;
                REG_STARTUP: begin
                    startup_next = cfg_wdata[START_W-1:0];
                    thr_next     = CFG_W'(cfg_wdata[START_W-1:0]);
                end
                default: ;
            endcase
        end

        if (s_accept) begin
            case (action_t'(s_action))
                ACT_TICK: begin
                    for (int k = 0; k < 2; k++) begin
                        if (key_reg[k].count != COUNT_MAX) begin
                            key_next[k].count = key_reg[k].count + COUNT_WIDTH'(1);
                        end
                    end
                end
                ACT_SCAN: begin
                    level_next = level_in;
                    key_next   = key_scan;
                    if (thr_reg != short_reg) begin
                        for (int k = 0; k < 2; k++) begin
                            if (key_scan[k].event_code != EV_NONE) begin
                                thr_next          = short_reg;
                                key_next[k].count = count_from_cfg(long_reg);
                            end
                        end
                    end
                end
                ACT_CLEAR: begin
                    for (int k = 0; k < 2; k++) begin
                        if (s_clear_mask[k]) begin
                            key_next[k].event_code = EV_NONE;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // result register
    always_comb begin
        m_valid_next = m_valid_reg;
        ev0_next     = ev0_reg;
        ev1_next     = ev1_reg;
        held0_next   = held0_reg;
        held1_next   = held1_reg;
        if (s_accept) begin
            m_valid_next = 1'b1;
            ev0_next     = key_next[0].event_code;
            ev1_next     = key_next[1].event_code;
            held0_next   = level_next[0];
            held1_next   = level_next[1];
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_reg     <= SHORT_RESET;
            long_reg      <= LONG_RESET;
            short_end_reg <= SHORT_END_RESET;
            startup_reg   <= STARTUP_RESET;
            thr_reg       <= CFG_W'(STARTUP_RESET);
            for (int k = 0; k < 2; k++) begin
                key_reg[k].count      <= '0;
                key_reg[k].event_code <= EV_NONE;
                key_reg[k].latched    <= 1'b0;
            end
            level_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            short_reg     <= short_next;
            long_reg      <= long_next;
            short_end_reg <= short_end_next;
            startup_reg   <= startup_next;
            thr_reg       <= thr_next;
            key_reg       <= key_next;
            level_reg     <= level_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ev0_reg   <= ev0_next;
        ev1_reg   <= ev1_next;
        held0_reg <= held0_next;
        held1_reg <= held1_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_key0_event = ev0_reg;
    assign m_key1_event = ev1_reg;
    assign m_key0_held  = held0_reg;
    assign m_key1_held  = held1_reg;

    // released key on scan leaves an empty counter once the release threshold equals the short setting
    `TKLSP_ASSERT_NEXT(a_release_clears0,
        s_accept && s_action == ACT_SCAN && !s_key0_down && thr_reg == short_reg,
        key_reg[0].count == '0 && !key_reg[0].latched)
    // accepted transaction always produces a result
    `TKLSP_ASSERT_NEXT(a_result_follows, s_accept, m_valid_reg)
    // shown levels match the sampled key state
    `TKLSP_ASSERT_NOW(a_held_matches, m_valid_reg,
        held0_reg == level_reg[0] && held1_reg == level_reg[1])

endmodule
